@@ hdl/llms_pkg.sv @@
// Shared types and constants for the leaky LMS adaptive FIR.
// Payload structs, register indexes, fixed-point constants, sequencer controls.
// No dependencies.
`default_nettype none

package llms_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int WEIGHT_FRAC = 20;   // weight fraction bits
    localparam int LEAK_SHIFT  = 10;   // aligns leak*w with mu*e*x (2^-46 units)
    localparam int UPD_SHIFT   = 26;   // 2^-46 -> 2^-20
    localparam int MUE_W       = 33;   // mu (unsigned 16) times e (signed 16)
    localparam int MX_W        = 49;   // mu*e times x

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_FACTOR = 2'd1;

    localparam logic [CFG_W-1:0] STEP_RESET = 16'd328;
    localparam logic [CFG_W-1:0] LEAK_RESET = 16'd65529;

    typedef struct packed {
        sample_t reference_sample;
        sample_t desired_sample;
    } in_item_t;

    typedef struct packed {
        sample_t estimate_sample;
        sample_t error_sample;
    } out_item_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic acc_clr;     // new item: clear accumulator, latch desired sample
        logic iss_filter;  // filter-pass read issued this cycle
        logic iss_update;  // update-pass read issued this cycle
        logic err_load;    // error formed: load result and mu*e
    } pass_ctl_t;

endpackage

`default_nettype wire

@@ hdl/llms_store.sv @@
// Tap weight and sample history memories, one write and one read port each.
// Synchronous (registered) read; zeroing write for the post-reset sweep.
// Depends on llms_pkg.
`default_nettype none

module llms_store #(
    parameter int TAPS         = 64,
    parameter int WEIGHT_WIDTH = 24
) (
    input  wire logic                            clk,
    input  wire logic                            clear,
    input  wire logic [$clog2(TAPS)-1:0]         clear_addr,
    input  wire logic [$clog2(TAPS)-1:0]         w_raddr,
    output logic signed [WEIGHT_WIDTH-1:0]       w_rdata,
    input  wire logic                            w_we,
    input  wire logic [$clog2(TAPS)-1:0]         w_waddr,
    input  wire logic signed [WEIGHT_WIDTH-1:0]  w_wdata,
    input  wire logic [$clog2(TAPS)-1:0]         h_raddr,
    output llms_pkg::sample_t                    h_rdata,
    input  wire logic                            h_we,
    input  wire logic [$clog2(TAPS)-1:0]         h_waddr,
    input  wire llms_pkg::sample_t               h_wdata
);
    import llms_pkg::*;

    logic signed [WEIGHT_WIDTH-1:0] w_mem [TAPS];
    sample_t                        h_mem [TAPS];

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            w_mem[clear_addr] <= '0;
        end
        else if (w_we)
        begin
            w_mem[w_waddr] <= w_wdata;
        end
        w_rdata <= w_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            h_mem[clear_addr] <= '0;
        end
        else if (h_we)
        begin
            h_mem[h_waddr] <= h_wdata;
        end
        h_rdata <= h_mem[h_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/llms_mac.sv @@
// Multiply-accumulate and weight update pipeline for the leaky LMS FIR.
// Read data -> products -> accumulate / new weight; saturation of y, e, w.
// Depends on llms_pkg.
`default_nettype none

module llms_mac #(
    parameter int TAPS         = 64,
    parameter int WEIGHT_WIDTH = 24
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire llms_pkg::pass_ctl_t             ctl,
    input  wire logic [$clog2(TAPS)-1:0]         rd_addr,
    input  wire logic signed [WEIGHT_WIDTH-1:0]  w_rdata,
    input  wire llms_pkg::sample_t               h_rdata,
    input  wire llms_pkg::sample_t               desired_sample,
    input  wire logic [llms_pkg::CFG_W-1:0]      step_size,
    input  wire logic [llms_pkg::CFG_W-1:0]      leak_factor,
    output logic                                 busy,
    output llms_pkg::sample_t                    estimate_sample,
    output llms_pkg::sample_t                    error_sample,
    output logic                                 w_we,
    output logic [$clog2(TAPS)-1:0]              w_waddr,
    output logic signed [WEIGHT_WIDTH-1:0]       w_wdata
);
    import llms_pkg::*;

    localparam int AW     = $clog2(TAPS);
    localparam int WH_W   = WEIGHT_WIDTH + SAMPLE_W;
    localparam int ACC_W  = WH_W + AW + 1;
    localparam int LW_W   = WEIGHT_WIDTH + CFG_W + 1;
    localparam int LWS_W  = LW_W + LEAK_SHIFT;
    localparam int UPD_W  = ((LWS_W > MX_W) ? LWS_W : MX_W) + 1;
    localparam logic signed [WEIGHT_WIDTH-1:0] W_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
    localparam logic signed [WEIGHT_WIDTH-1:0] W_MIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};

    // pipeline valids
    logic v1_f_reg, v1_u_reg, v2_f_reg, v2_u_reg, v3_u_reg;
    logic [AW-1:0] k1_reg, k2_reg, k3_reg;

    sample_t                        d_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [MUE_W-1:0]        mue_reg;
    logic signed [WH_W-1:0]         prod_wh_reg;
    logic signed [LW_W-1:0]         prod_lw_reg;
    logic signed [MX_W-1:0]         prod_mx_reg;
    logic signed [WEIGHT_WIDTH-1:0] nw_reg;

    logic signed [ACC_W-1:0]        acc_sh;
    logic [ACC_W-16:0]              y_hi;
    logic signed [SAMPLE_W:0]       diff;
    logic signed [UPD_W-1:0]        upd_sum;
    logic signed [UPD_W-1:0]        upd_sh;
    logic [UPD_W-WEIGHT_WIDTH:0]    w_hi;
    logic signed [WEIGHT_WIDTH-1:0] nw_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_f_reg <= 1'b0;
            v1_u_reg <= 1'b0;
            v2_f_reg <= 1'b0;
            v2_u_reg <= 1'b0;
            v3_u_reg <= 1'b0;
        end
        else
        begin
            v1_f_reg <= ctl.iss_filter;
            v1_u_reg <= ctl.iss_update;
            v2_f_reg <= v1_f_reg;
            v2_u_reg <= v1_u_reg;
            v3_u_reg <= v2_u_reg;
        end
    end

    assign busy = v1_f_reg | v1_u_reg | v2_f_reg | v2_u_reg | v3_u_reg;

    // y = sat16(acc >>> 20)
    assign acc_sh = acc_reg >>> WEIGHT_FRAC;
    assign y_hi   = acc_sh[ACC_W-1:SAMPLE_W-1];

    always_comb
    begin
        if ((&y_hi) || !(|y_hi))
        begin
            estimate_sample = acc_sh[SAMPLE_W-1:0];
        end
        else
        begin
            estimate_sample = acc_sh[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end
    end

    // e = sat16(d - y)
    assign diff = (SAMPLE_W+1)'(d_reg) - (SAMPLE_W+1)'(estimate_sample);

    always_comb
    begin
        if (diff[SAMPLE_W] == diff[SAMPLE_W-1])
        begin
            error_sample = diff[SAMPLE_W-1:0];
        end
        else
        begin
            error_sample = diff[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
        end
    end

    // new weight = sat(((leak*w) << 10 + mu*e*x) >>> 26)
    assign upd_sum = (UPD_W'(prod_lw_reg) <<< LEAK_SHIFT) + UPD_W'(prod_mx_reg);
    assign upd_sh  = upd_sum >>> UPD_SHIFT;
    assign w_hi    = upd_sh[UPD_W-1:WEIGHT_WIDTH-1];

    always_comb
    begin
        if ((&w_hi) || !(|w_hi))
        begin
            nw_next = upd_sh[WEIGHT_WIDTH-1:0];
        end
        else
        begin
            nw_next = upd_sh[UPD_W-1] ? W_MIN : W_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg      <= rd_addr;
        k2_reg      <= k1_reg;
        k3_reg      <= k2_reg;
        prod_wh_reg <= w_rdata * h_rdata;
        prod_lw_reg <= $signed({1'b0, leak_factor}) * w_rdata;
        prod_mx_reg <= mue_reg * h_rdata;
        nw_reg      <= nw_next;
        if (ctl.acc_clr)
        begin
            d_reg   <= desired_sample;
            acc_reg <= '0;
        end
        else if (v2_f_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_wh_reg);
        end
        if (ctl.err_load)
        begin
            mue_reg <= $signed({1'b0, step_size}) * error_sample;
        end
    end

    assign w_we    = v3_u_reg;
    assign w_waddr = k3_reg;
    assign w_wdata = nw_reg;

endmodule

`default_nettype wire

@@ hdl/llms_seq.sv @@
// Pass sequencer: post-reset zeroing sweep, filter pass, error, update pass.
// Generates memory addresses, history pointer and datapath controls.
// Depends on llms_pkg.
`default_nettype none

module llms_seq #(
    parameter int TAPS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     out_free,
    input  wire logic                     busy,
    output llms_pkg::pass_ctl_t           ctl,
    output logic                          clear,
    output logic [$clog2(TAPS)-1:0]       rd_addr,
    output logic [$clog2(TAPS)-1:0]       hist_addr,
    output logic                          h_we,
    output logic [$clog2(TAPS)-1:0]       wp
);
    import llms_pkg::*;

    localparam int AW = $clog2(TAPS);
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_FILTER = 7'b0000100,
        ST_FDRAIN = 7'b0001000,
        ST_ERR    = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_UDRAIN = 7'b1000000
    } seq_state_t;

    seq_state_t    state_reg, state_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] hidx_reg, hidx_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] hidx_dec;
    logic          k_last;

    assign k_last   = (k_reg == LAST);
    assign hidx_dec = (hidx_reg == '0) ? LAST : hidx_reg - AW'(1);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        hidx_next  = hidx_reg;
        wp_next    = wp_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        clear      = 1'b0;
        h_we       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear = 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    h_we        = 1'b1;
                    ctl.acc_clr = 1'b1;
                    k_next      = '0;
                    hidx_next   = wp_reg;
                    state_next  = ST_FILTER;
                end
            end
            ST_FILTER:
            begin
                ctl.iss_filter = 1'b1;
                hidx_next      = hidx_dec;
                k_next         = k_reg + AW'(1);
                if (k_last)
                begin
                    k_next     = '0;
                    hidx_next  = wp_reg;
                    state_next = ST_FDRAIN;
                end
            end
            ST_FDRAIN:
            begin
                if (!busy)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    ctl.err_load = 1'b1;
                    state_next   = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ctl.iss_update = 1'b1;
                hidx_next      = hidx_dec;
                k_next         = k_reg + AW'(1);
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_UDRAIN;
                end
            end
            ST_UDRAIN:
            begin
                if (!busy)
                begin
                    wp_next    = (wp_reg == LAST) ? '0 : wp_reg + AW'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            k_reg     <= '0;
            hidx_reg  <= '0;
            wp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            hidx_reg  <= hidx_next;
            wp_reg    <= wp_next;
        end
    end

    assign rd_addr   = k_reg;
    assign hist_addr = hidx_reg;
    assign wp        = wp_reg;

endmodule

`default_nettype wire

@@ hdl/leaky_lms_adaptive_fir.sv @@
// Leaky LMS adaptive FIR (top level). Deps: llms_pkg, llms_store, llms_mac, llms_seq.
// One MAC per tap per pass; a new item is accepted only after the update pass of
// the previous item has finished. The result is registered at the error step.
// Reset: asynchronous, active low; then a sweep over all taps zeroes both memories
// while in_ready stays low. step_size and leak_factor reset to 328 and 65529.
`default_nettype none

// Per item: the reference sample is written into the history ring at the write
// pointer, a filter pass reads weight k and the sample k steps back for every
// tap and accumulates w*x, the estimate and error are formed and registered
// into the output, and an update pass reads each weight and sample again and
// writes back leak*w + mu*e*x. Weight reads run ahead of write-backs via the
// k1/k2/k3 address registers, always at different taps, so no forwarding
// is needed. The output register decouples the consumer: the next item is
// taken while a result still waits, and only the error step stalls if the
// previous result was not yet transferred.
module leaky_lms_adaptive_fir #(
    parameter int TAPS         = 64,
    parameter int WEIGHT_WIDTH = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire llms_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output llms_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_write,
    input  wire logic [llms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [llms_pkg::CFG_W-1:0]     cfg_data
);
    import llms_pkg::*;

    localparam int AW = $clog2(TAPS);

    // configuration registers
    logic [CFG_W-1:0] step_reg;
    logic [CFG_W-1:0] leak_reg;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    // sequencer
    pass_ctl_t     ctl;
    logic          clear;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] hist_addr;
    logic          h_we;
    logic [AW-1:0] wp;
    logic          busy;
    logic          out_free;

    // memories and datapath
    logic signed [WEIGHT_WIDTH-1:0] w_rdata;
    sample_t                        h_rdata;
    logic                           w_we;
    logic [AW-1:0]                  w_waddr;
    logic signed [WEIGHT_WIDTH-1:0] w_wdata;
    sample_t                        estimate;
    sample_t                        error;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            leak_reg <= LEAK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STEP_SIZE:   step_reg <= cfg_data;
                REG_LEAK_FACTOR: leak_reg <= cfg_data;
                default:         ;  // unmapped index: write dropped
            endcase
        end
    end

    // slot is free if empty or being transferred this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.err_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.err_load)
        begin
            out_data_reg.estimate_sample <= estimate;
            out_data_reg.error_sample    <= error;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    llms_seq #(
        .TAPS (TAPS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_free  (out_free),
        .busy      (busy),
        .ctl       (ctl),
        .clear     (clear),
        .rd_addr   (rd_addr),
        .hist_addr (hist_addr),
        .h_we      (h_we),
        .wp        (wp)
    );

    llms_store #(
        .TAPS         (TAPS),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_store (
        .clk        (clk),
        .clear      (clear),
        .clear_addr (rd_addr),
        .w_raddr    (rd_addr),
        .w_rdata    (w_rdata),
        .w_we       (w_we),
        .w_waddr    (w_waddr),
        .w_wdata    (w_wdata),
        .h_raddr    (hist_addr),
        .h_rdata    (h_rdata),
        .h_we       (h_we),
        .h_waddr    (wp),
        .h_wdata    (in_data.reference_sample)
    );

    llms_mac #(
        .TAPS         (TAPS),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_mac (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .rd_addr         (rd_addr),
        .w_rdata         (w_rdata),
        .h_rdata         (h_rdata),
        .desired_sample  (in_data.desired_sample),
        .step_size       (step_reg),
        .leak_factor     (leak_reg),
        .busy            (busy),
        .estimate_sample (estimate),
        .error_sample    (error),
        .w_we            (w_we),
        .w_waddr         (w_waddr),
        .w_wdata         (w_wdata)
    );

endmodule

`default_nettype wire

@@ dv/llms_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the leaky LMS adaptive FIR: tracks register writes, predicts
// y and error for every input transfer and compares output transfers in order.
// Depends on llms_pkg.
module llms_checker #(
    parameter int TAPS         = 64,
    parameter int WEIGHT_WIDTH = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire llms_pkg::in_item_t             in_data,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire llms_pkg::out_item_t            out_data,
    input  wire logic                           cfg_write,
    input  wire logic [llms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [llms_pkg::CFG_W-1:0]     cfg_data,
    output int                                  mismatches,
    output int                                  outstanding
);
    import llms_pkg::*;

    logic signed [WEIGHT_WIDTH-1:0] coeffs [TAPS];
    sample_t                        ref_ring [TAPS];
    int                             ring_pos;
    logic [CFG_W-1:0]               mu;
    logic [CFG_W-1:0]               leak;
    out_item_t                      queued_estimates [$];
    int                             fail_count;

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // One filter pass, error, then one leaky update pass over all taps.
    function automatic out_item_t filter_and_adapt(input in_item_t item);
        longint    acc;
        longint    y;
        longint    e;
        longint    leaked;
        longint    grad;
        int        idx;
        out_item_t res;
        ref_ring[ring_pos] = item.reference_sample;
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
            idx = (ring_pos + TAPS - k) % TAPS;
            acc += longint'(coeffs[k]) * longint'(ref_ring[idx]);
        end
        y = clamp(acc >>> WEIGHT_FRAC, SAMPLE_W);
        e = clamp(longint'(item.desired_sample) - y, SAMPLE_W);
        for (int k = 0; k < TAPS; k++) begin
            idx = (ring_pos + TAPS - k) % TAPS;
            leaked = longint'(leak) * longint'(coeffs[k]) * 1024;
            grad = longint'(mu) * e * longint'(ref_ring[idx]);
            coeffs[k] = clamp((leaked + grad) >>> UPD_SHIFT, WEIGHT_WIDTH);
        end
        ring_pos = (ring_pos + 1) % TAPS;
        res.estimate_sample = sample_t'(y);
        res.error_sample    = sample_t'(e);
        return res;
    endfunction

    task automatic flag(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            mu = STEP_RESET;
            leak = LEAK_RESET;
            ring_pos = 0;
            for (int k = 0; k < TAPS; k++)
            begin
                coeffs[k] = '0;
                ref_ring[k] = '0;
            end
            queued_estimates.delete();
            fail_count = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_STEP_SIZE:   mu = cfg_data;
                    REG_LEAK_FACTOR: leak = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (queued_estimates.size() == 0)
                    flag($sformatf("unexpected result y=%0d e=%0d",
                                   out_data.estimate_sample, out_data.error_sample));
                else
                begin
                    want = queued_estimates.pop_front();
                    if (out_data.estimate_sample !== want.estimate_sample)
                        flag($sformatf("estimate expected %0d got %0d",
                                       want.estimate_sample, out_data.estimate_sample));
                    if (out_data.error_sample !== want.error_sample)
                        flag($sformatf("error expected %0d got %0d",
                                       want.error_sample, out_data.error_sample));
                end
            end
            if (in_valid && in_ready)
                queued_estimates.push_back(filter_and_adapt(in_data));
            outstanding <= queued_estimates.size();
            mismatches <= fail_count;
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the leaky LMS adaptive FIR testbench: clock, reset, stimulus and verdict.
// Depends on llms_pkg, leaky_lms_adaptive_fir and llms_checker.
module testbench;
    import llms_pkg::*;

    localparam int TAPS         = 64;
    localparam int WEIGHT_WIDTH = 24;
    // Time for one item's passes plus margin before touching registers
    localparam int DRAIN_CYCLES = 2 * TAPS + 24;
    // Longest quiet stretch on both channels before the run is declared hung
    localparam int STALL_LIMIT  = 6000;
    localparam int PHASE_ITEMS  = 240;
    localparam int PHASES       = 8;

    // Indexes with no register behind them; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {FREE_FLOW, SRC_SPARSE, SINK_SLOW, BOTH_BUSY} traffic_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   mismatches;
    int                   outstanding;
    int                   src_idle_pct = 0;
    int                   sink_stall_pct = 0;
    int                   quiet_cycles = 0;

    always #10 clk = ~clk;

    leaky_lms_adaptive_fir #(
        .TAPS         (TAPS),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    llms_checker #(
        .TAPS         (TAPS),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Sink side: ready is redrawn every cycle from the current stall rate.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Hang detection: any transfer on either channel resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic set_traffic(input traffic_t mode);
        case (mode)
            FREE_FLOW:  begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
            SRC_SPARSE: begin src_idle_pct <= 80; sink_stall_pct <= 0;  end
            SINK_SLOW:  begin src_idle_pct <= 0;  sink_stall_pct <= 80; end
            default:    begin src_idle_pct <= 14; sink_stall_pct <= 14; end
        endcase
    endtask

    // Back-to-back register writes; write enable drops after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_write <= 1'b0;
    endtask

    // Valid stays up between items unless an idle gap is drawn, so a
    // back-to-back transfer never sees valid dropped and raised in one step.
    task automatic send_item(input in_item_t item);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    // Source pauses until every result has left the block, then waits out the
    // update pass of the last item so a register write cannot land inside it.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic sample_t pick_extreme();
        return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    endfunction

    // Mostly a reference with a desired signal that follows it through a short
    // path (something the filter can learn), with some noise and full-scale hits.
    function automatic in_item_t random_pair(input sample_t last_ref);
        in_item_t it;
        int       pick;
        int       noise;
        pick = $urandom_range(99);
        noise = int'($urandom_range(510)) - 255;
        if (pick < 10)
        begin
            it.reference_sample = pick_extreme();
            it.desired_sample   = pick_extreme();
        end
        else
        begin
            if (pick < 25)
                it.reference_sample = sample_t'(int'($urandom_range(511)) - 256);
            else
                it.reference_sample = sample_t'($urandom);
            if (pick < 70)
                it.desired_sample = sample_t'(int'(last_ref >>> 1)
                                              + int'(it.reference_sample >>> 2) + noise);
            else
                it.desired_sample = sample_t'($urandom);
        end
        return it;
    endfunction

    initial
    begin
        in_item_t         item;
        sample_t          last_ref;
        logic [CFG_W-1:0] step_val;
        logic [CFG_W-1:0] leak_val;

        last_ref = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Writes to unmapped indexes must leave the reset values in place
        write_reg(REG_SPARE_A, CFG_W'($urandom));
        write_reg(REG_SPARE_B, CFG_W'($urandom));
        end_writes();
        set_traffic(FREE_FLOW);

        // Full-scale corners at the reset step size and leakage
        send_item('{reference_sample: 16'sd0,     desired_sample: 16'sd0});
        send_item('{reference_sample: SAMPLE_MAX, desired_sample: SAMPLE_MAX});
        send_item('{reference_sample: SAMPLE_MIN, desired_sample: SAMPLE_MIN});
        send_item('{reference_sample: SAMPLE_MAX, desired_sample: SAMPLE_MIN});
        send_item('{reference_sample: SAMPLE_MIN, desired_sample: SAMPLE_MAX});
        send_item('{reference_sample: 16'sd1,     desired_sample: -16'sd1});
        send_item('{reference_sample: -16'sd1,    desired_sample: 16'sd1});
        send_item('{reference_sample: 16'sh5555,  desired_sample: 16'shAAAA});
        drain();

        // Largest step, least leakage: alternating full-scale input drives the
        // estimate, the error and the weights into their clamps
        write_reg(REG_STEP_SIZE, 16'hFFFF);
        write_reg(REG_LEAK_FACTOR, 16'hFFFF);
        end_writes();
        for (int i = 0; i < 16; i++)
        begin
            item.reference_sample = (i % 2 == 1) ? SAMPLE_MIN : SAMPLE_MAX;
            item.desired_sample   = (i % 3 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
            send_item(item);
        end
        drain();

        // Random phases, each with its own register setting and a traffic pattern set by p % 4
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin step_val = 16'd0;      leak_val = 16'd0;      end
                1: begin step_val = 16'hFFFF;   leak_val = 16'hFFFF;   end
                2: begin step_val = STEP_RESET; leak_val = LEAK_RESET; end
                3: begin step_val = 16'd0;      leak_val = 16'hFFFF;   end
                4: begin step_val = 16'hFFFF;   leak_val = 16'd0;      end
                5:
                begin
                    step_val = CFG_W'($urandom_range(2000, 1));
                    leak_val = CFG_W'($urandom_range(65535, 65000));
                end
                default:
                begin
                    step_val = CFG_W'($urandom_range(65535));
                    leak_val = CFG_W'($urandom_range(65535));
                end
            endcase
            write_reg(REG_STEP_SIZE, step_val);
            write_reg(REG_LEAK_FACTOR, leak_val);
            write_reg((p % 2 == 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
            end_writes();
            set_traffic(traffic_t'(p % 4));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                item = random_pair(last_ref);
                last_ref = item.reference_sample;
                send_item(item);
            end
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/llms_pkg.sv
hdl/llms_store.sv
hdl/llms_mac.sv
hdl/llms_seq.sv
hdl/leaky_lms_adaptive_fir.sv
dv/llms_checker.sv
dv/testbench.sv
